### rtl/scoc_pkg.sv
// Shared types and constants for the split count occupancy chooser.
// Used by scoc_div and the top level split_count_occupancy_chooser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scoc_pkg;

    // Field and register widths.
    localparam int UNITS_W  = 16;
    localparam int BLOCKS_W = 16;
    localparam int CFG_W    = 8;
    localparam int SPLIT_W  = 8;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] CORE_COUNT_RESET  = 8'd40;
    localparam logic [CFG_W-1:0] SPLIT_LIMIT_RESET = 8'd128;
    localparam int SPLIT_CAP_DEFAULT = 128;

    // Ceiling divider: a 16-bit dividend plus a divisor less one needs 17 bits.
    localparam int DVD_W   = 17;
    localparam int DVS_W   = 8;
    localparam int STEP_W  = $clog2(DVD_W);

    // Efficiency terms. Scanning only happens when 5*units < 4*cores, so
    // units stays below 204 and units*s and cores*ceil(units*s/cores)
    // both fit in 16 bits for any split count up to 255.
    localparam int EFF_W  = 16;
    localparam int PROD_W = 2 * EFF_W;
    localparam int CMP_W  = PROD_W + 5;

    typedef struct packed {
        logic                 start;
        logic [BLOCKS_W-1:0]  dividend;
        logic [DVS_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DVD_W-1:0]     quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### rtl/split_count_occupancy_chooser.sv
// Split count occupancy chooser: one sequencer with a shared multiplier
// driving the bit-serial ceiling divider scoc_div. Uses scoc_pkg.
//
// Takes work_units and kv_blocks and returns the split count whose wave
// efficiency, units*s / (cores*ceil(units*s/cores)), is the first to reach
// 85 percent of the best over the eligible counts, all compared exactly.
// When 5*work_units >= 4*core_count, when work_units is zero, or when the
// scan range min(split_limit, core_count, kv_blocks, SPLIT_CAP) is empty,
// the answer is 1. Otherwise two scans run over that range; each visited
// count takes a serial ceiling division of kv_blocks, and each eligible
// count a second division, three passes through the multiplier and the
// compare. A new transaction is taken only while the sequencer is idle;
// the result sits in an output register, so the next transaction can be
// taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module split_count_occupancy_chooser #(
    parameter int SPLIT_CAP = scoc_pkg::SPLIT_CAP_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [scoc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scoc_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [scoc_pkg::UNITS_W-1:0]    s_work_units,
    input  wire logic [scoc_pkg::BLOCKS_W-1:0]   s_kv_blocks,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [scoc_pkg::SPLIT_W-1:0]         m_split_count
);
    import scoc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BPS_START,
        ST_BPS_WAIT,
        ST_WDIV_START,
        ST_WDIV_WAIT,
        ST_MUL_DEN,
        ST_MUL_P1,
        ST_MUL_P2,
        ST_COMPARE,
        ST_ADVANCE,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     core_count_reg, core_count_next;
    logic [CFG_W-1:0]     split_limit_reg, split_limit_next;
    logic [UNITS_W-1:0]   units_reg, units_next;
    logic [BLOCKS_W-1:0]  blocks_reg, blocks_next;
    logic                 pick_phase_reg, pick_phase_next;
    logic [SPLIT_W-1:0]   scan_index_reg, scan_index_next;
    logic [SPLIT_W-1:0]   top_reg, top_next;
    logic [BLOCKS_W-1:0]  prev_bps_reg, prev_bps_next;
    logic [EFF_W-1:0]     w_reg, w_next;
    logic [EFF_W-1:0]     k_reg, k_next;
    logic [EFF_W-1:0]     den_reg, den_next;
    logic [EFF_W-1:0]     best_num_reg, best_num_next;
    logic [EFF_W-1:0]     best_den_reg, best_den_next;
    logic [PROD_W-1:0]    p1_reg, p1_next;
    logic [PROD_W-1:0]    p2_reg, p2_next;
    logic                 m_valid_reg, m_valid_next;
    logic [SPLIT_W-1:0]   m_split_count_reg, m_split_count_next;

    logic [SPLIT_W:0]     top_calc;
    logic [UNITS_W+2:0]   five_units;
    logic [CFG_W+1:0]     four_cores;
    logic [EFF_W-1:0]     mul_a, mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [CMP_W-1:0]     lhs_scaled, rhs_scaled;
    logic [BLOCKS_W-1:0]  div_q;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    scoc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign div_q = div_rsp.quotient[BLOCKS_W-1:0];

    // The one multiplier, shared by the denominator and both cross products.
    always_comb begin
        mul_a = w_reg;
        mul_b = best_den_reg;
        case (state_reg)
            ST_MUL_DEN: begin
                mul_a = EFF_W'(core_count_reg);
                mul_b = k_reg;
            end
            ST_MUL_P2: begin
                mul_a = best_num_reg;
                mul_b = den_reg;
            end
            default: begin
                mul_a = w_reg;
                mul_b = best_den_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // 20*p1 against 17*p2 for the 85 percent test, by shifts and adds.
    assign lhs_scaled = (CMP_W'(p1_reg) << 4) + (CMP_W'(p1_reg) << 2);
    assign rhs_scaled = (CMP_W'(p2_reg) << 4) + CMP_W'(p2_reg);

    assign five_units = (UNITS_W+3)'(units_reg) * (UNITS_W+3)'(5);
    assign four_cores = {core_count_reg, 2'b00};

    always_comb begin
        top_calc = {1'b0, split_limit_reg};
        if ({1'b0, core_count_reg} < top_calc) begin
            top_calc = {1'b0, core_count_reg};
        end
        if (blocks_reg < BLOCKS_W'(top_calc)) begin
            top_calc = (SPLIT_W+1)'(blocks_reg);
        end
        if ((SPLIT_W+1)'(SPLIT_CAP) < top_calc) begin
            top_calc = (SPLIT_W+1)'(SPLIT_CAP);
        end
    end

    always_comb begin
        state_next         = state_reg;
        core_count_next    = core_count_reg;
        split_limit_next   = split_limit_reg;
        units_next         = units_reg;
        blocks_next        = blocks_reg;
        pick_phase_next    = pick_phase_reg;
        scan_index_next    = scan_index_reg;
        top_next           = top_reg;
        prev_bps_next      = prev_bps_reg;
        w_next             = w_reg;
        k_next             = k_reg;
        den_next           = den_reg;
        best_num_next      = best_num_reg;
        best_den_next      = best_den_reg;
        p1_next            = p1_reg;
        p2_next            = p2_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_split_count_next = m_split_count_reg;
        div_req.start      = 1'b0;
        div_req.dividend   = blocks_reg;
        div_req.divisor    = scan_index_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_CORE_COUNT:  core_count_next  = cfg_wdata;
                REG_SPLIT_LIMIT: split_limit_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    units_next  = s_work_units;
                    blocks_next = s_kv_blocks;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                top_next = top_calc[SPLIT_W-1:0];
                if (five_units >= (UNITS_W+3)'(four_cores) || units_reg == '0
                    || top_calc == '0) begin
                    scan_index_next = SPLIT_W'(1);
                    state_next      = ST_FINISH;
                end else begin
                    pick_phase_next = 1'b0;
                    scan_index_next = SPLIT_W'(1);
                    w_next          = EFF_W'(units_reg);
                    prev_bps_next   = '0;
                    best_num_next   = '0;
                    best_den_next   = EFF_W'(1);
                    state_next      = ST_BPS_START;
                end
            end
            ST_BPS_START: begin
                div_req.start = 1'b1;
                state_next    = ST_BPS_WAIT;
            end
            ST_BPS_WAIT: begin
                if (div_rsp.done) begin
                    prev_bps_next = div_q;
                    // Only counts that change the blocks per split are eligible.
                    if (scan_index_reg == SPLIT_W'(1) || div_q != prev_bps_reg) begin
                        state_next = ST_WDIV_START;
                    end else begin
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_WDIV_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = w_reg;
                div_req.divisor  = core_count_reg;
                state_next       = ST_WDIV_WAIT;
            end
            ST_WDIV_WAIT: begin
                if (div_rsp.done) begin
                    k_next     = div_q;
                    state_next = ST_MUL_DEN;
                end
            end
            ST_MUL_DEN: begin
                den_next   = mul_p[EFF_W-1:0];
                state_next = ST_MUL_P1;
            end
            ST_MUL_P1: begin
                p1_next    = mul_p;
                state_next = ST_MUL_P2;
            end
            ST_MUL_P2: begin
                p2_next    = mul_p;
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                state_next = ST_ADVANCE;
                if (!pick_phase_reg) begin
                    if (p1_reg > p2_reg) begin
                        best_num_next = w_reg;
                        best_den_next = den_reg;
                    end
                end else if (lhs_scaled >= rhs_scaled) begin
                    // The chosen count stays in scan_index_reg until it is loaded.
                    state_next = ST_FINISH;
                end
            end
            ST_ADVANCE: begin
                if (scan_index_reg == top_reg) begin
                    if (!pick_phase_reg) begin
                        pick_phase_next = 1'b1;
                        scan_index_next = SPLIT_W'(1);
                        w_next          = EFF_W'(units_reg);
                        prev_bps_next   = '0;
                        state_next      = ST_BPS_START;
                    end else begin
                        scan_index_next = SPLIT_W'(1);
                        state_next      = ST_FINISH;
                    end
                end else begin
                    scan_index_next = scan_index_reg + SPLIT_W'(1);
                    w_next          = w_reg + EFF_W'(units_reg);
                    state_next      = ST_BPS_START;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_split_count_next = scan_index_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            core_count_reg  <= CORE_COUNT_RESET;
            split_limit_reg <= SPLIT_LIMIT_RESET;
            pick_phase_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            core_count_reg  <= core_count_next;
            split_limit_reg <= split_limit_next;
            pick_phase_reg  <= pick_phase_next;
            m_valid_reg     <= m_valid_next;
        end
        units_reg         <= units_next;
        blocks_reg        <= blocks_next;
        scan_index_reg    <= scan_index_next;
        top_reg           <= top_next;
        prev_bps_reg      <= prev_bps_next;
        w_reg             <= w_next;
        k_reg             <= k_next;
        den_reg           <= den_next;
        best_num_reg      <= best_num_next;
        best_den_reg      <= best_den_next;
        p1_reg            <= p1_next;
        p2_reg            <= p2_next;
        m_split_count_reg <= m_split_count_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_split_count = m_split_count_reg;

    // A delivered split count is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_split_count != '0)
        else $error("split count of zero presented");

    // While scanning, the split index stays within 1 .. top.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BPS_START || state_reg == ST_WDIV_START
         || state_reg == ST_COMPARE || state_reg == ST_ADVANCE)
        |-> (scan_index_reg != '0 && scan_index_reg <= top_reg))
        else $error("scan index out of range");

    // The best denominator is a product of positive terms, never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_P1 || state_reg == ST_COMPARE) |-> best_den_reg != '0)
        else $error("best efficiency denominator is zero");

    // A result is loaded only from the finish state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish state");

endmodule

`default_nettype wire

### rtl/scoc_div.sv
// Bit-serial ceiling divider, one quotient bit per cycle.
// Computes ceil(dividend / divisor) for a nonzero divisor; uses scoc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scoc_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire scoc_pkg::div_req_t req,
    output scoc_pkg::div_rsp_t      rsp
);
    import scoc_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DVS_W:0]      trial;

    // Restoring division; the quotient bits shift into the dividend register.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dvd_next  = dvd_reg;
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvs_next  = req.divisor;
            dvd_next  = DVD_W'(req.dividend) + DVD_W'(req.divisor) - DVD_W'(1);
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dvd_reg <= dvd_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

`default_nettype wire

### verif/tb_split_count_occupancy_chooser.sv
// Self-checking testbench for split_count_occupancy_chooser.
// Predicts each chosen split count with an exact integer scan; needs scoc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_split_count_occupancy_chooser;
    import scoc_pkg::*;

    localparam int SPLIT_CAP = SPLIT_CAP_DEFAULT;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int HOLD_CYCLES = 10000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [UNITS_W-1:0]  units;
        logic [BLOCKS_W-1:0] blocks;
    } launch_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CORE_COUNT;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [UNITS_W-1:0] s_work_units = '0;
    logic [BLOCKS_W-1:0] s_kv_blocks = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [SPLIT_W-1:0] m_split_count;

    // Register copies used by the predictor.
    int unsigned core_cfg = CORE_COUNT_RESET;
    int unsigned limit_cfg = SPLIT_LIMIT_RESET;

    launch_t launch_q[$];
    logic [SPLIT_W-1:0] split_expect_q[$];

    int unsigned launches_queued = 0;
    int unsigned launches_taken = 0;
    int unsigned scans_taken = 0;
    int unsigned splits_checked = 0;
    int unsigned splits_above_one = 0;
    int unsigned settings_used = 1;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    bit steady_flow = 1'b0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int unsigned hold_left = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;

    split_count_occupancy_chooser #(
        .SPLIT_CAP(SPLIT_CAP)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_work_units(s_work_units),
        .s_kv_blocks(s_kv_blocks),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_split_count(m_split_count)
    );

    always #10 aclk = ~aclk;

    function automatic int unsigned ceil_quot(input int unsigned num, input int unsigned dvs);
        return (num + dvs - 1) / dvs;
    endfunction

    function automatic bit needs_scan(input logic [UNITS_W-1:0] units);
        return (5 * units < 4 * core_cfg) && (units != 0);
    endfunction

    // Two passes over the eligible split counts: the first finds the best wave
    // efficiency, the second returns the first count within 85 percent of it.
    function automatic logic [SPLIT_W-1:0] pick_split_count(input logic [UNITS_W-1:0] units,
            input logic [BLOCKS_W-1:0] blocks);
        int unsigned top, s, bps, prev, w, den;
        longint unsigned best_num, best_den;
        bit elig;
        if (!needs_scan(units)) return SPLIT_W'(1);
        top = limit_cfg;
        if (core_cfg < top) top = core_cfg;
        if (blocks < top) top = blocks;
        if (SPLIT_CAP < top) top = SPLIT_CAP;
        best_num = 0;
        best_den = 1;
        prev = 0;
        for (s = 1; s <= top; s++) begin
            bps = ceil_quot(blocks, s);
            elig = (s == 1) || (bps != prev);
            prev = bps;
            if (elig) begin
                w = units * s;
                den = core_cfg * ceil_quot(w, core_cfg);
                if (64'(w) * best_den > best_num * den) begin
                    best_num = w;
                    best_den = den;
                end
            end
        end
        prev = 0;
        for (s = 1; s <= top; s++) begin
            bps = ceil_quot(blocks, s);
            elig = (s == 1) || (bps != prev);
            prev = bps;
            if (elig) begin
                w = units * s;
                den = core_cfg * ceil_quot(w, core_cfg);
                if (64'd20 * w * best_den >= 64'd17 * best_num * den) return SPLIT_W'(s);
            end
        end
        return SPLIT_W'(1);
    endfunction

    // Most launches are small enough to start a scan; the rest are arbitrary.
    function automatic launch_t draw_launch();
        launch_t l;
        int unsigned room;
        room = (core_cfg == 0) ? 0 : (4 * core_cfg - 1) / 5;
        if ($urandom_range(0, 3) != 0 && room != 0) begin
            l.units = UNITS_W'($urandom_range(1, room));
            l.blocks = ($urandom_range(0, 3) == 0) ? BLOCKS_W'($urandom_range(0, 65535))
                                                   : BLOCKS_W'($urandom_range(0, 300));
        end else begin
            l.units = UNITS_W'($urandom);
            l.blocks = BLOCKS_W'($urandom);
        end
        return l;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
            input int unsigned want);
        $display("tb: mismatch on %s at cycle %0d: got %0d, expected %0d",
                 what, cycle_count, got, want);
        mismatches++;
    endtask

    task automatic queue_launch(input int unsigned units, input int unsigned blocks);
        launch_t l;
        l.units = UNITS_W'(units);
        l.blocks = BLOCKS_W'(blocks);
        launch_q.insert(launch_q.size(), l);
        launches_queued++;
    endtask

    // Returns at a rising edge once every launch has been taken and answered.
    task automatic wait_drained();
        do @(posedge aclk);
        while (launch_q.size() != 0 || launches_taken != launches_queued ||
               split_expect_q.size() != 0);
    endtask

    task automatic program_regs(input int unsigned cores, input int unsigned limit);
        cfg_we <= 1'b1;
        cfg_index <= REG_CORE_COUNT;
        cfg_wdata <= CFG_W'(cores);
        @(posedge aclk);
        cfg_index <= REG_SPLIT_LIMIT;
        cfg_wdata <= CFG_W'(limit);
        @(posedge aclk);
        cfg_we <= 1'b0;
        core_cfg = cores;
        limit_cfg = limit;
        settings_used++;
    endtask

    // Launch driver: the prediction is made when the transaction is accepted.
    always @(posedge aclk) begin
        launch_t l;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_work_units <= '0;
            s_kv_blocks <= '0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                split_expect_q.insert(split_expect_q.size(),
                                      pick_split_count(s_work_units, s_kv_blocks));
                if (needs_scan(s_work_units)) scans_taken++;
                launches_taken++;
                send_wait = steady_flow ? 0 : $urandom_range(0, 19);
            end
            if (!s_valid || s_ready) begin
                if (send_wait != 0 || launch_q.size() == 0) begin
                    if (send_wait != 0) send_wait--;
                    s_valid <= 1'b0;
                end else begin
                    l = launch_q.pop_front();
                    s_valid <= 1'b1;
                    s_work_units <= l.units;
                    s_kv_blocks <= l.blocks;
                end
            end
        end
    end

    // Result monitor with its own stall pattern and the long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (split_expect_q.size() == 0) begin
                    report_mismatch("unexpected split_count", m_split_count, 0);
                end else begin
                    if (m_split_count != split_expect_q[0])
                        report_mismatch("split_count", m_split_count, split_expect_q[0]);
                    void'(split_expect_q.pop_front());
                end
                splits_checked++;
                if (m_split_count > 1) splits_above_one++;
                recv_wait = steady_flow ? 0 : $urandom_range(0, 19);
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_wait != 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int phase;
        int unsigned cores, limit;
        launch_t pending;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: the threshold on either side, empty and single-count
        // ranges, and the field extremes.
        queue_launch(0, 0);
        queue_launch(65535, 65535);
        queue_launch(31, 65535);
        queue_launch(32, 1000);
        queue_launch(1, 1);
        queue_launch(1, 0);
        queue_launch(7, 100);
        queue_launch(3, 5);

        // Widest settings: the longest scans the block can run.
        wait_drained();
        program_regs(255, 255);
        queue_launch(203, 65535);
        queue_launch(204, 65535);
        queue_launch(1, 300);
        queue_launch(100, 128);
        queue_launch(17, 200);

        // No cores at all, then a zero split limit, then one-wide ranges.
        wait_drained();
        program_regs(0, 0);
        queue_launch(0, 0);
        queue_launch(65535, 77);
        wait_drained();
        program_regs(40, 0);
        queue_launch(5, 50);
        wait_drained();
        program_regs(255, 1);
        queue_launch(10, 10);
        wait_drained();
        program_regs(1, 1);
        queue_launch(0, 5);
        queue_launch(1, 5);

        for (phase = 0; phase < 5; phase++) begin
            wait_drained();
            steady_flow = (phase == 2);
            if (phase == 4) begin
                cores = $urandom_range(128, 255);
                limit = $urandom_range(1, 40);
            end else begin
                cores = $urandom_range(1, 64);
                limit = (phase == 1) ? 255 : $urandom_range(1, 128);
            end
            program_regs(cores, limit);
            repeat (16) begin
                pending = draw_launch();
                queue_launch(pending.units, pending.blocks);
            end
        end

        // The receiver stalls for a long stretch while launches keep coming,
        // so the output register fills and the input side backs up.
        wait_drained();
        program_regs(CORE_COUNT_RESET, SPLIT_LIMIT_RESET);
        steady_flow = 1'b1;
        hold_request = 1'b1;
        repeat (8) begin
            pending = draw_launch();
            queue_launch(pending.units, pending.blocks);
        end

        wait_drained();
        steady_flow = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d launches checked, %0d of them scanned, %0d answers above one,",
                 splits_checked, scans_taken, splits_above_one);
        $display("tb: across %0d register settings, with %0d mismatches", settings_used,
                 mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
rtl/scoc_pkg.sv
rtl/scoc_div.sv
rtl/split_count_occupancy_chooser.sv
verif/tb_split_count_occupancy_chooser.sv
